>>> rtl/cgll_pkg.sv
// Package for the color glyph layer lookup block.
// Holds the beat structs, command and register codes and fixed field offsets.
// Used by: color_glyph_layer_lookup_core.
package cgll_pkg;

   // Commands carried in the request beat.
   typedef enum logic [1:0] {
      CMD_WR_COLR = 2'd0,
      CMD_WR_CPAL = 2'd1,
      CMD_GET_LAYERS = 2'd2,
      CMD_HAS_GLYPH = 2'd3
   } cmd_type;

   // Configuration register indexes.
   localparam logic CSR_COLR_LENGTH = 1'b0;
   localparam logic CSR_CPAL_LENGTH = 1'b1;

   // Table layout constants.
   localparam int unsigned COLR_HDR_BYTES = 14;
   localparam int unsigned CPAL_HDR_BYTES = 12;
   localparam logic [15:0] FOREGROUND_INDEX = 16'hFFFF;
   localparam logic [7:0] OPAQUE = 8'd255;

   typedef struct packed {
      logic [1:0] command;
      logic [13:0] address;
      logic [7:0] byte_value;
      logic [15:0] glyph_id;
      logic [6:0] max_layers;
   } req_type;

   typedef struct packed {
      logic [15:0] layer_glyph;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic layer_valid;
      logic glyph_found;
      logic last;
   } rsp_type;

endpackage

>>> rtl/cgll_ram.sv
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
module cgll_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input logic clock,
   input logic wr_en,
   input logic [$clog2(DEPTH)-1:0] wr_addr,
   input logic [WIDTH-1:0] wr_data,
   input logic rd_en,
   input logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/color_glyph_layer_lookup_core.sv
// Color glyph layer lookup: COLR v0 base record search and CPAL palette 0 colors.
// Table write beats go straight to memory. A query fetches the COLR header, runs a binary
// search of the base records and fetches each emitted layer record and its palette color,
// through the one-byte-per-cycle read port of each table memory. One beat at a time is worked.
// Synchronous reset clears the sequencer, the result slot and both length registers; the
// table memories hold nothing defined until written.
// Depends on cgll_pkg and cgll_ram.
module color_glyph_layer_lookup_core #(
   parameter int COLR_DEPTH = 16384,
   parameter int CPAL_DEPTH = 4096,
   parameter int MAX_LAYERS = 64
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input cgll_pkg::req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output cgll_pkg::rsp_type rsp_data,
   input logic csr_we,
   input logic csr_index,
   input logic [14:0] csr_wdata
);

   localparam int CAW = $clog2(COLR_DEPTH);
   localparam int PAW = $clog2(CPAL_DEPTH);
   localparam int FAW = (CAW > PAW) ? CAW : PAW;

   typedef enum logic [11:0] {
      ST_IDLE = 12'b000000000001,
      ST_FETCH = 12'b000000000010,
      ST_HDR_CHK = 12'b000000000100,
      ST_SRCH = 12'b000000001000,
      ST_SRCH_CMP = 12'b000000010000,
      ST_REC_CHK = 12'b000000100000,
      ST_LAYER = 12'b000001000000,
      ST_LAYER_CHK = 12'b000010000000,
      ST_PAL_HDR = 12'b000100000000,
      ST_PAL_IDX = 12'b001000000000,
      ST_PAL_REC = 12'b010000000000,
      ST_EMIT = 12'b100000000000
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;

   logic [14:0] colr_length_ff, colr_length_in;
   logic [12:0] cpal_length_ff, cpal_length_in;

   logic cmd_get_ff, cmd_get_in;
   logic [15:0] glyph_id_ff, glyph_id_in;
   logic [6:0] max_layers_ff, max_layers_in;

   logic [31:0] base_off_ff, base_off_in;
   logic [31:0] layer_off_ff, layer_off_in;
   logic [15:0] num_layer_rec_ff, num_layer_rec_in;
   logic [15:0] search_low_ff, search_low_in;
   logic [16:0] search_high_ff, search_high_in;
   logic [15:0] mid_ff, mid_in;
   logic [33:0] rec_pos_ff, rec_pos_in;
   logic [15:0] first_layer_ff, first_layer_in;
   logic [6:0] num_emit_ff, num_emit_in;
   logic [6:0] layer_counter_ff, layer_counter_in;
   logic [15:0] pal_index_ff, pal_index_in;
   logic [15:0] num_colors_ff, num_colors_in;
   logic [31:0] color_off_ff, color_off_in;

   // Byte fetch sequencer state.
   logic fetch_cpal_ff, fetch_cpal_in;
   logic [FAW-1:0] fetch_addr_ff, fetch_addr_in;
   logic [3:0] issue_left_ff, issue_left_in;
   logic [3:0] recv_left_ff, recv_left_in;
   logic rd_pend_ff, rd_pend_in;
   logic [111:0] acc_ff, acc_in;

   // Result staging and output slot.
   cgll_pkg::rsp_type res_ff, res_in;
   logic res_more_ff, res_more_in;
   cgll_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic req_accept;
   logic colr_we, cpal_we, colr_re, cpal_re;
   logic [31:0] wr_addr_wide;
   logic [7:0] colr_rdata, cpal_rdata, rd_byte;
   logic [33:0] colr_eff, cpal_eff;
   logic [6:0] max_sat;
   logic [33:0] start_addr;
   logic [3:0] start_n;
   logic start_cpal, start_fetch;
   state_type start_ret;
   logic slot_free;

   // Helper values for the check states.
   logic [33:0] hdr_base_end, hdr_layer_end;
   logic [16:0] mid_sum;
   logic [16:0] rec_span;
   logic [15:0] rec_num;
   logic [16:0] layer_idx;
   logic [33:0] layer_pos;
   logic [33:0] pal_arr_end;
   logic [15:0] color_idx;
   logic [33:0] color_rec_end;
   logic [33:0] color_rec_pos;

   assign req_accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Table writes go straight to memory; the sequencer never reads while a write is taken.
   assign wr_addr_wide = 32'(req_data.address);
   assign colr_we = req_accept && (req_data.command == cgll_pkg::CMD_WR_COLR)
                    && (wr_addr_wide < 32'(COLR_DEPTH));
   assign cpal_we = req_accept && (req_data.command == cgll_pkg::CMD_WR_CPAL)
                    && (wr_addr_wide < 32'(CPAL_DEPTH));
   assign colr_re = (state_ff == ST_FETCH) && (issue_left_ff != 4'd0) && !fetch_cpal_ff;
   assign cpal_re = (state_ff == ST_FETCH) && (issue_left_ff != 4'd0) && fetch_cpal_ff;
   assign rd_byte = fetch_cpal_ff ? cpal_rdata : colr_rdata;

   cgll_ram #(.WIDTH(8), .DEPTH(COLR_DEPTH)) u_colr_ram (
      .clock (clock),
      .wr_en (colr_we),
      .wr_addr(wr_addr_wide[CAW-1:0]),
      .wr_data(req_data.byte_value),
      .rd_en (colr_re),
      .rd_addr(fetch_addr_ff[CAW-1:0]),
      .rd_data(colr_rdata)
   );

   cgll_ram #(.WIDTH(8), .DEPTH(CPAL_DEPTH)) u_cpal_ram (
      .clock (clock),
      .wr_en (cpal_we),
      .wr_addr(wr_addr_wide[PAW-1:0]),
      .wr_data(req_data.byte_value),
      .rd_en (cpal_re),
      .rd_addr(fetch_addr_ff[PAW-1:0]),
      .rd_data(cpal_rdata)
   );

   // Lengths saturate at the memory depth and the layer limit at MAX_LAYERS.
   assign colr_eff = (34'(colr_length_ff) < 34'(COLR_DEPTH)) ? 34'(colr_length_ff)
                     : 34'(COLR_DEPTH);
   assign cpal_eff = (34'(cpal_length_ff) < 34'(CPAL_DEPTH)) ? 34'(cpal_length_ff)
                     : 34'(CPAL_DEPTH);
   assign max_sat = (req_data.max_layers > 7'(MAX_LAYERS)) ? 7'(MAX_LAYERS)
                    : req_data.max_layers;

   // Arithmetic used by the check states.
   assign hdr_base_end = 34'(acc_ff[79:48]) + 34'(acc_ff[95:80]) * 34'd6;
   assign hdr_layer_end = 34'(acc_ff[47:16]) + {16'd0, acc_ff[15:0], 2'b00};
   assign mid_sum = 17'(search_low_ff) + search_high_ff - 17'd1;
   assign rec_span = 17'(acc_ff[31:16]) + 17'(acc_ff[15:0]);
   assign rec_num = acc_ff[15:0];
   assign layer_idx = 17'(first_layer_ff) + 17'(layer_counter_ff);
   assign layer_pos = 34'(layer_off_ff) + {15'd0, layer_idx, 2'b00};
   assign pal_arr_end = 34'(cgll_pkg::CPAL_HDR_BYTES) + {17'd0, acc_ff[63:48], 1'b0};
   assign color_idx = acc_ff[15:0] + pal_index_ff;
   assign color_rec_pos = 34'(color_off_ff) + {16'd0, color_idx, 2'b00};
   assign color_rec_end = color_rec_pos + 34'd4;

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      colr_length_in = colr_length_ff;
      cpal_length_in = cpal_length_ff;
      cmd_get_in = cmd_get_ff;
      glyph_id_in = glyph_id_ff;
      max_layers_in = max_layers_ff;
      base_off_in = base_off_ff;
      layer_off_in = layer_off_ff;
      num_layer_rec_in = num_layer_rec_ff;
      search_low_in = search_low_ff;
      search_high_in = search_high_ff;
      mid_in = mid_ff;
      rec_pos_in = rec_pos_ff;
      first_layer_in = first_layer_ff;
      num_emit_in = num_emit_ff;
      layer_counter_in = layer_counter_ff;
      pal_index_in = pal_index_ff;
      num_colors_in = num_colors_ff;
      color_off_in = color_off_ff;
      fetch_cpal_in = fetch_cpal_ff;
      fetch_addr_in = fetch_addr_ff;
      issue_left_in = issue_left_ff;
      recv_left_in = recv_left_ff;
      rd_pend_in = 1'b0;
      acc_in = acc_ff;
      res_in = res_ff;
      res_more_in = res_more_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      start_fetch = 1'b0;
      start_cpal = 1'b0;
      start_addr = '0;
      start_n = 4'd0;
      start_ret = ST_IDLE;

      // Configuration writes.
      if (csr_we) begin
         if (csr_index == cgll_pkg::CSR_COLR_LENGTH) begin
            colr_length_in = csr_wdata;
         end else begin
            cpal_length_in = csr_wdata[12:0];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_data.command == cgll_pkg::CMD_GET_LAYERS
                               || req_data.command == cgll_pkg::CMD_HAS_GLYPH)) begin
               cmd_get_in = (req_data.command == cgll_pkg::CMD_GET_LAYERS);
               glyph_id_in = req_data.glyph_id;
               max_layers_in = max_sat;
               res_in = '0;
               res_in.last = 1'b1;
               res_more_in = 1'b0;
               if (cmd_get_in && (max_sat == 7'd0 || cpal_length_ff == 13'd0)) begin
                  state_in = ST_EMIT;
               end else if (colr_eff < 34'(cgll_pkg::COLR_HDR_BYTES)) begin
                  state_in = ST_EMIT;
               end else begin
                  start_fetch = 1'b1;
                  start_addr = '0;
                  start_n = 4'(cgll_pkg::COLR_HDR_BYTES);
                  start_ret = ST_HDR_CHK;
               end
            end
         end

         // One byte read issued and one captured per cycle.
         ST_FETCH: begin
            if (issue_left_ff != 4'd0) begin
               rd_pend_in = 1'b1;
               issue_left_in = issue_left_ff - 4'd1;
               fetch_addr_in = fetch_addr_ff + FAW'(1);
            end
            if (rd_pend_ff) begin
               acc_in = {acc_ff[103:0], rd_byte};
               recv_left_in = recv_left_ff - 4'd1;
               if (recv_left_ff == 4'd1) begin
                  state_in = ret_ff;
               end
            end
         end

         // COLR header: version, base records and layer records within length.
         ST_HDR_CHK: begin
            base_off_in = acc_ff[79:48];
            layer_off_in = acc_ff[47:16];
            num_layer_rec_in = acc_ff[15:0];
            search_low_in = '0;
            search_high_in = 17'(acc_ff[95:80]);
            if (acc_ff[111:96] != 16'd0 || hdr_base_end > colr_eff
                || hdr_layer_end > colr_eff) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_SRCH;
            end
         end

         ST_SRCH: begin
            if (17'(search_low_ff) < search_high_ff) begin
               mid_in = mid_sum[16:1];
               rec_pos_in = 34'(base_off_ff) + 34'(mid_sum[16:1]) * 34'd6;
               start_fetch = 1'b1;
               start_addr = rec_pos_in;
               start_n = 4'd2;
               start_ret = ST_SRCH_CMP;
            end else begin
               state_in = ST_EMIT;
            end
         end

         ST_SRCH_CMP: begin
            if (acc_ff[15:0] == glyph_id_ff) begin
               if (!cmd_get_ff) begin
                  res_in.glyph_found = 1'b1;
                  state_in = ST_EMIT;
               end else begin
                  start_fetch = 1'b1;
                  start_addr = rec_pos_ff + 34'd2;
                  start_n = 4'd4;
                  start_ret = ST_REC_CHK;
               end
            end else begin
               if (acc_ff[15:0] < glyph_id_ff) begin
                  search_low_in = mid_ff + 16'd1;
               end else begin
                  search_high_in = 17'(mid_ff);
               end
               state_in = ST_SRCH;
            end
         end

         // Base record: layer range check and clamp to the caller's limit.
         ST_REC_CHK: begin
            first_layer_in = acc_ff[31:16];
            num_emit_in = (rec_num > 16'(max_layers_ff)) ? max_layers_ff : rec_num[6:0];
            layer_counter_in = '0;
            if (rec_span > 17'(num_layer_rec_ff) || num_emit_in == 7'd0) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_LAYER;
            end
         end

         ST_LAYER: begin
            start_fetch = 1'b1;
            start_addr = layer_pos;
            start_n = 4'd4;
            start_ret = ST_LAYER_CHK;
         end

         // Layer record; black is loaded first and replaced when the palette checks pass.
         ST_LAYER_CHK: begin
            pal_index_in = acc_ff[15:0];
            res_in = '0;
            res_in.layer_glyph = acc_ff[31:16];
            res_in.alpha = cgll_pkg::OPAQUE;
            res_in.layer_valid = 1'b1;
            res_in.last = (layer_counter_ff + 7'd1 == num_emit_ff);
            res_more_in = !res_in.last;
            if (acc_ff[15:0] == cgll_pkg::FOREGROUND_INDEX
                || cpal_eff < 34'(cgll_pkg::CPAL_HDR_BYTES)) begin
               state_in = ST_EMIT;
            end else begin
               start_fetch = 1'b1;
               start_cpal = 1'b1;
               start_addr = 34'd4;
               start_n = 4'd8;
               start_ret = ST_PAL_HDR;
            end
         end

         ST_PAL_HDR: begin
            num_colors_in = acc_ff[47:32];
            color_off_in = acc_ff[31:0];
            if (acc_ff[63:48] == 16'd0 || pal_arr_end > cpal_eff) begin
               state_in = ST_EMIT;
            end else begin
               start_fetch = 1'b1;
               start_cpal = 1'b1;
               start_addr = 34'(cgll_pkg::CPAL_HDR_BYTES);
               start_n = 4'd2;
               start_ret = ST_PAL_IDX;
            end
         end

         ST_PAL_IDX: begin
            if (color_idx >= num_colors_ff || color_rec_end > cpal_eff) begin
               state_in = ST_EMIT;
            end else begin
               start_fetch = 1'b1;
               start_cpal = 1'b1;
               start_addr = color_rec_pos;
               start_n = 4'd4;
               start_ret = ST_PAL_REC;
            end
         end

         // Color record bytes are blue, green, red, alpha.
         ST_PAL_REC: begin
            res_in.blue = acc_ff[31:24];
            res_in.green = acc_ff[23:16];
            res_in.red = acc_ff[15:8];
            res_in.alpha = acc_ff[7:0];
            state_in = ST_EMIT;
         end

         ST_EMIT: begin
            if (slot_free) begin
               rsp_data_in = res_ff;
               rsp_valid_in = 1'b1;
               if (res_more_ff) begin
                  layer_counter_in = layer_counter_ff + 7'd1;
                  state_in = ST_LAYER;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Launch a byte fetch.
      if (start_fetch) begin
         state_in = ST_FETCH;
         ret_in = start_ret;
         fetch_cpal_in = start_cpal;
         fetch_addr_in = start_addr[FAW-1:0];
         issue_left_in = start_n;
         recv_left_in = start_n;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
         colr_length_ff <= '0;
         cpal_length_ff <= '0;
         search_low_ff <= '0;
         search_high_ff <= '0;
         layer_counter_ff <= '0;
         issue_left_ff <= '0;
         recv_left_ff <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff <= rd_pend_in;
         colr_length_ff <= colr_length_in;
         cpal_length_ff <= cpal_length_in;
         search_low_ff <= search_low_in;
         search_high_ff <= search_high_in;
         layer_counter_ff <= layer_counter_in;
         issue_left_ff <= issue_left_in;
         recv_left_ff <= recv_left_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_get_ff <= cmd_get_in;
      glyph_id_ff <= glyph_id_in;
      max_layers_ff <= max_layers_in;
      base_off_ff <= base_off_in;
      layer_off_ff <= layer_off_in;
      num_layer_rec_ff <= num_layer_rec_in;
      mid_ff <= mid_in;
      rec_pos_ff <= rec_pos_in;
      first_layer_ff <= first_layer_in;
      num_emit_ff <= num_emit_in;
      pal_index_ff <= pal_index_in;
      num_colors_ff <= num_colors_in;
      color_off_ff <= color_off_in;
      fetch_cpal_ff <= fetch_cpal_in;
      fetch_addr_ff <= fetch_addr_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
      res_more_ff <= res_more_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule
